[rtl/csu_pkg.sv]
// Package for the cosine similarity unit: datapath widths, counter loads
// and the sequencer state type. It depends on nothing else.
package csu_pkg;

	localparam int ELEM_W   = 16;
	localparam int MPY_W    = 2 * ELEM_W;
	localparam int SQ_W     = MPY_W - 1;
	localparam int DOT_W    = 41;
	localparam int NORM_W   = 40;
	localparam int WORK_W   = 2 * NORM_W;
	localparam int ROOT_W   = NORM_W;
	localparam int REM_W    = ROOT_W + 3;
	localparam int FRAC_W   = 15;
	localparam int DVD_W    = DOT_W + FRAC_W;
	localparam int CNT_W    = 6;

	localparam logic [CNT_W-1:0] MUL_LAST_BIT  = CNT_W'(NORM_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST_BIT = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST_BIT  = CNT_W'(DVD_W - 1);

	localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
	localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
	localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

	localparam logic [ELEM_W-1:0] SIM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] SIM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC_DOT,
		ST_MAC_NA,
		ST_MAC_NB,
		ST_CHECK,
		ST_MUL,
		ST_SQRT,
		ST_DIV_LOAD,
		ST_DIV,
		ST_EMIT
	} csu_state_t;

endpackage

[rtl/cosine_similarity_unit.sv]
// Cosine similarity unit: streaming dot product and norms of two Q4.12
// vectors, followed by an iterative product, square root and divide.
// Depends on csu_pkg.
//
//   channel   direction  handshake          payload
//   input     in         valid / ready      elem_a, elem_b, last
//   output    out        out_valid / out_ready  similarity, zero_norm
//
// Every item goes through one register stage and one pass of the shared 16x16
// multiplier for each of the three sums. A last item then adds a check step
// and, unless a norm is zero, 40 shift-add steps for the norm product, 40
// square root steps, a load step and 56 restoring divide steps; a final step
// hands over the result. The single sequencer runs all of these steps.
// Reset clears the sums, the sequencer and the output valid flag.
// A finished result waits in the output register while new items are taken;
// only a second result stalls until the first one has been taken.
module cosine_similarity_unit
	import csu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     ready,
	input  logic signed [ELEM_W-1:0] elem_a,
	input  logic signed [ELEM_W-1:0] elem_b,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ELEM_W-1:0] similarity,
	output logic                     zero_norm
);

	csu_state_t state_q, state_d;

	logic signed [ELEM_W-1:0] a_q, b_q;
	logic                     last_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic [NORM_W-1:0]        na_q, nb_q;
	logic [WORK_W-1:0]        work_q;
	logic [ROOT_W-1:0]        root_q;
	logic [REM_W-1:0]         rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic                     zn_q;
	logic                     out_valid_q;
	logic signed [ELEM_W-1:0] sim_q;
	logic                     zero_norm_q;

	// Shared multiplier and accumulators
	logic signed [ELEM_W-1:0] mul_x, mul_y;
	logic signed [MPY_W-1:0]  mul_p;
	logic signed [DOT_W:0]    dot_sum;
	logic [NORM_W-1:0]        norm_cur;
	logic [NORM_W:0]          norm_sum;
	logic [NORM_W-1:0]        norm_sat;
	logic [DOT_W-1:0]         dot_sat;

	// Iterative steps
	logic [WORK_W-1:0] mul_step;
	logic [REM_W-1:0]  sq_rem, sq_trial, sq_diff;
	logic              sq_ge;
	logic [DOT_W-1:0]  dv_rem, dv_div;
	logic              dv_ge;
	logic [DOT_W-1:0]  dot_mag;
	logic [DVD_W-1:0]  quot;
	logic [ELEM_W-1:0] sim_res;

	logic take_in, emit_fire, cnt_done;

	assign ready     = (state_q == ST_IDLE);
	assign take_in   = valid && ready;
	assign out_valid = out_valid_q;
	assign similarity = sim_q;
	assign zero_norm = zero_norm_q;
	assign cnt_done  = (cnt_q == '0);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (state_q)
			ST_MAC_NA: begin
				mul_x = a_q;
				mul_y = a_q;
			end
			ST_MAC_NB: begin
				mul_x = b_q;
				mul_y = b_q;
			end
			default: begin
				mul_x = a_q;
				mul_y = b_q;
			end
		endcase
	end

	assign mul_p   = mul_x * mul_y;
	assign dot_sum = {dot_q[DOT_W-1], dot_q} + (DOT_W+1)'(mul_p);

	always_comb begin
		if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
			dot_sat = dot_sum[DOT_W] ? DOT_MIN : DOT_MAX;
		end else begin
			dot_sat = dot_sum[DOT_W-1:0];
		end
	end

	// A square is never negative, so its low bits are taken as unsigned.
	assign norm_cur = (state_q == ST_MAC_NA) ? na_q : nb_q;
	assign norm_sum = {1'b0, norm_cur} + (NORM_W+1)'(mul_p[SQ_W-1:0]);
	assign norm_sat = norm_sum[NORM_W] ? NORM_MAX : norm_sum[NORM_W-1:0];

	// Norm product, most significant multiplier bit first.
	assign mul_step = {work_q[WORK_W-2:0], 1'b0} +
		(nb_q[cnt_q] ? WORK_W'(na_q) : '0);

	// Digit-by-digit square root, two radicand bits per step.
	assign sq_rem   = {rem_q[REM_W-3:0], work_q[WORK_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = (sq_rem >= sq_trial);
	assign sq_diff  = sq_rem - sq_trial;

	// Restoring divide, quotient bits shift in from the bottom of work_q.
	assign dv_rem = {rem_q[ROOT_W-1:0], work_q[DVD_W-1]};
	assign dv_div = {1'b0, root_q};
	assign dv_ge  = (dv_rem >= dv_div);

	assign dot_mag = dot_q[DOT_W-1] ? (~dot_q + DOT_W'(1)) : dot_q;

	assign quot = work_q[DVD_W-1:0];
	always_comb begin
		if (neg_q) begin
			sim_res = (quot > DVD_W'(SIM_MIN)) ? SIM_MIN : (~quot[ELEM_W-1:0] + ELEM_W'(1));
		end else begin
			sim_res = (quot > DVD_W'(SIM_MAX)) ? SIM_MAX : quot[ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (take_in) state_d = ST_MAC_DOT;
			ST_MAC_DOT:  state_d = ST_MAC_NA;
			ST_MAC_NA:   state_d = ST_MAC_NB;
			ST_MAC_NB:   state_d = last_q ? ST_CHECK : ST_IDLE;
			ST_CHECK: begin
				if (na_q == '0 || nb_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:      if (cnt_done) state_d = ST_SQRT;
			ST_SQRT:     if (cnt_done) state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV:      if (cnt_done) state_d = ST_EMIT;
			ST_EMIT:     if (emit_fire) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sums and flags that must start from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_MAC_DOT: dot_q <= dot_sat;
				ST_MAC_NA:  na_q  <= norm_sat;
				ST_MAC_NB:  nb_q  <= norm_sat;
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid_q <= 1'b1;
						dot_q       <= '0;
						na_q        <= '0;
						nb_q        <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the iterative unit; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					a_q    <= elem_a;
					b_q    <= elem_b;
					last_q <= last;
				end
			end
			ST_CHECK: begin
				zn_q   <= (na_q == '0 || nb_q == '0);
				work_q <= '0;
				cnt_q  <= MUL_LAST_BIT;
			end
			ST_MUL: begin
				work_q <= mul_step;
				cnt_q  <= cnt_done ? SQRT_LAST_BIT : cnt_q - CNT_W'(1);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				work_q <= {work_q[WORK_W-3:0], 2'b00};
				rem_q  <= sq_ge ? sq_diff : sq_rem;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_DIV_LOAD: begin
				neg_q  <= dot_q[DOT_W-1];
				work_q <= WORK_W'({dot_mag, {FRAC_W{1'b0}}});
				rem_q  <= '0;
				cnt_q  <= DIV_LAST_BIT;
			end
			ST_DIV: begin
				rem_q  <= REM_W'(dv_ge ? (dv_rem - dv_div) : dv_rem);
				work_q <= WORK_W'({work_q[DVD_W-2:0], dv_ge});
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_EMIT: begin
				if (emit_fire) begin
					sim_q       <= zn_q ? '0 : sim_res;
					zero_norm_q <= zn_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for cosine_similarity_unit: directed extreme vectors and
// random vectors, each result checked against a typed value or a behavioral predictor.
// Depends on csu_pkg and the cosine_similarity_unit RTL.
module tb_top
	import csu_pkg::*;
();

	typedef struct packed {
		logic signed [ELEM_W-1:0] sim;
		logic                     zn;
	} sim_result_t;

	typedef struct {
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic                     lst;
		bit                       typed;
		logic signed [ELEM_W-1:0] sim;
		logic                     zn;
	} stim_row_t;

	typedef enum int {
		MIX_FULL,
		MIX_SMALL,
		MIX_SAME,
		MIX_OPPOSITE,
		MIX_NEAR,
		MIX_ZERO_SIDE
	} vec_mix_t;

	localparam longint DOT_HI = 64'sd1099511627775;
	localparam longint DOT_LO = -64'sd1099511627776;
	localparam longint unsigned NORM_HI = 64'd1099511627775;
	localparam int RANDOM_ITEMS = 620;
	localparam int HOLD_CYCLES = 800;

	logic                     clk;
	logic                     arst_n;
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [ELEM_W-1:0] similarity;
	logic                     zero_norm;

	// Predictor state: the three running sums of the vector in flight.
	logic signed [DOT_W-1:0] dot_acc = '0;
	logic [NORM_W-1:0]       norm_a_acc = '0;
	logic [NORM_W-1:0]       norm_b_acc = '0;

	// New expectations enter at the front; the oldest one leaves from the back.
	sim_result_t sim_expected_q [$];
	int          errors = 0;
	int          results_done = 0;

	// Expected values are typed in only where they follow directly from the inputs.
	stim_row_t directed_rows [24] = '{
		'{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 1'b1},
		'{16'sh1000, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 1'b1},
		'{16'sh0000, 16'sh7FFF, 1'b1, 1'b1, 16'sh0000, 1'b1},
		'{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b0},
		'{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'sh8000, 1'b0},
		'{16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF, 1'b0},
		'{16'sh0001, 16'shFFFF, 1'b1, 1'b1, 16'sh8000, 1'b0},
		'{16'sh0001, 16'sh0001, 1'b1, 1'b1, 16'sh7FFF, 1'b0},
		'{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b0},
		'{16'sh1000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0000, 16'sh1000, 1'b1, 1'b1, 16'sh0000, 1'b0},
		'{16'sh1000, 16'sh0800, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0800, 16'sh1000, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'shF000, 16'sh0C00, 1'b1, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0000, 16'sh5555, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0000, 16'shAAAA, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0000, 16'sh0001, 1'b1, 1'b1, 16'sh0000, 1'b1},
		'{16'sh1234, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0000, 16'sh5678, 1'b1, 1'b1, 16'sh0000, 1'b0},
		'{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0123, 16'shFEDC, 1'b1, 1'b0, 16'sh0000, 1'b0},
		'{16'sh0003, 16'sh0002, 1'b0, 1'b0, 16'sh0000, 1'b0},
		'{16'shFFFE, 16'sh0005, 1'b1, 1'b0, 16'sh0000, 1'b0}
	};

	cosine_similarity_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.ready      (ready),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.similarity (similarity),
		.zero_norm  (zero_norm)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Adds one element pair to the sums; on the last pair it produces the similarity
	// and clears the sums.
	function automatic void cos_sim_predict(input logic signed [ELEM_W-1:0] a,
		input logic signed [ELEM_W-1:0] b, input logic lst,
		output bit produced, output sim_result_t res);
		longint                  dsum;
		longint unsigned         sa;
		longint unsigned         sb;
		logic [WORK_W-1:0]       norm_prod;
		logic [DOT_W-1:0]        root;
		logic [DOT_W-1:0]        trial;
		logic [DOT_W-1:0]        dot_mag;
		logic [2*DOT_W-1:0]      trial_sq;
		logic [DVD_W-1:0]        quot;
		bit                      neg;
		dsum = longint'(dot_acc) + longint'(a) * longint'(b);
		if (dsum > DOT_HI) dsum = DOT_HI;
		if (dsum < DOT_LO) dsum = DOT_LO;
		sa = longint'(norm_a_acc) + longint'(longint'(a) * longint'(a));
		sb = longint'(norm_b_acc) + longint'(longint'(b) * longint'(b));
		if (sa > NORM_HI) sa = NORM_HI;
		if (sb > NORM_HI) sb = NORM_HI;
		dot_acc = dsum[DOT_W-1:0];
		norm_a_acc = sa[NORM_W-1:0];
		norm_b_acc = sb[NORM_W-1:0];
		produced = lst;
		res = '0;
		if (lst) begin
			if (norm_a_acc == '0 || norm_b_acc == '0) begin
				res.zn = 1'b1;
			end else begin
				norm_prod = WORK_W'(norm_a_acc) * WORK_W'(norm_b_acc);
				root = '0;
				// Floor square root, one bit per step from the top.
				for (int k = DOT_W - 1; k >= 0; k--) begin
					trial = root | (DOT_W'(1) << k);
					trial_sq = (2*DOT_W)'(trial) * (2*DOT_W)'(trial);
					if (trial_sq <= (2*DOT_W)'(norm_prod)) root = trial;
				end
				neg = dot_acc[DOT_W-1];
				dot_mag = neg ? DOT_W'(-dot_acc) : DOT_W'(dot_acc);
				quot = {dot_mag, {FRAC_W{1'b0}}} / DVD_W'(root);
				if (neg) begin
					res.sim = (quot > DVD_W'(32768)) ? 16'sh8000 : ELEM_W'(-quot);
				end else begin
					res.sim = (quot > DVD_W'(32767)) ? 16'sh7FFF : ELEM_W'(quot);
				end
			end
			dot_acc = '0;
			norm_a_acc = '0;
			norm_b_acc = '0;
		end
	endfunction

	task automatic send_item(input logic signed [ELEM_W-1:0] a,
		input logic signed [ELEM_W-1:0] b, input logic lst, input bit no_gap,
		input bit typed, input sim_result_t typed_res);
		int          gap;
		bit          produced;
		sim_result_t res;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		elem_a <= a;
		elem_b <= b;
		last <= lst;
		do @(posedge clk); while (ready !== 1'b1);
		cos_sim_predict(a, b, lst, produced, res);
		if (produced) sim_expected_q.push_front(typed ? typed_res : res);
	endtask

	task automatic check_result(input logic signed [ELEM_W-1:0] got_sim, input logic got_zn);
		sim_result_t want;
		results_done++;
		if (sim_expected_q.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected: similarity %0d zero_norm %0b",
				$time, got_sim, got_zn);
		end else begin
			want = sim_expected_q.pop_back();
			if (want.sim !== got_sim) begin
				errors++;
				$display("%0t: similarity expected %0d actual %0d", $time, want.sim, got_sim);
			end
			if (want.zn !== got_zn) begin
				errors++;
				$display("%0t: zero_norm expected %0b actual %0b", $time, want.zn, got_zn);
			end
		end
	endtask

	// Result side: random stalls, calm stretches, and one long hold-off that lets
	// the block fill up and stall its input.
	initial begin : result_drain
		int stall;
		int calm_left;
		bit held_off;
		out_ready = 1'b0;
		calm_left = 0;
		held_off = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!held_off && results_done == 20) begin
				held_off = 1'b1;
				stall = HOLD_CYCLES;
			end else if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = $urandom_range(0, 4);
				if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(4, 12);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result(similarity, zero_norm);
		end
	end

	initial begin : stimulus
		int                       random_items;
		int                       len;
		vec_mix_t                 mix;
		bit                       burst;
		bit                       zero_b;
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		arst_n = 1'b0;
		valid = 1'b0;
		elem_a = '0;
		elem_b = '0;
		last = 1'b0;
		random_items = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].lst, 1'b0,
				directed_rows[i].typed, '{directed_rows[i].sim, directed_rows[i].zn});
		end

		while (random_items < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			mix = vec_mix_t'($urandom_range(0, 5));
			burst = ($urandom_range(0, 3) == 0);
			zero_b = $urandom_range(0, 1);
			for (int i = 0; i < len; i++) begin
				a = ELEM_W'($urandom);
				b = ELEM_W'($urandom);
				case (mix)
					MIX_SMALL: begin
						a = ELEM_W'(int'($urandom_range(0, 127)) - 64);
						b = ELEM_W'(int'($urandom_range(0, 127)) - 64);
					end
					MIX_SAME: b = a;
					MIX_OPPOSITE: b = -a;
					MIX_NEAR: b = a + ELEM_W'(int'($urandom_range(0, 31)) - 16);
					MIX_ZERO_SIDE: begin
						if (zero_b) b = '0;
						else a = '0;
					end
					default: ;
				endcase
				send_item(a, b, i == len - 1, burst, 1'b0, '0);
			end
			random_items += len;
		end
		valid <= 1'b0;

		while (sim_expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#(4_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
